// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file dgr_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define DGR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("dgr assertion failed");

// checked at every edge, reset included
`define DGR_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("dgr assertion failed");

`endif

// ----- rtl/dgr_pkg.sv -----
// shared types, constants and helper functions of the reachability block
package dgr_pkg;

   localparam int NODES  = 64;
   localparam int NODE_W = 6;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [NODES-1:0]  row_type;

   typedef enum logic [1:0] {
      OP_QUERY  = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_A,
      ST_WR_A,
      ST_RD_B,
      ST_WR_B,
      ST_Q_INIT,
      ST_Q_RUN,
      ST_Q_OUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_A,
      SEL_B,
      SEL_PICK
   } sel_type;

   typedef struct packed {
      logic    load;
      logic    rd_en;
      sel_type rd_sel;
      logic    wr_en;
      sel_type wr_sel;
      logic    q_init;
      logic    expand;
      logic    emit;
   } cmd_type;

   typedef struct packed {
      logic edit_ok;
      logic q_done;
      logic rsp_free;
   } status_type;

   function automatic logic in_range(input node_type n);
      in_range = (int'(n) < NODES);
   endfunction

   // lowest set bit of a non-empty vector
   function automatic node_type first_set(input row_type v);
      node_type idx;
      idx = '0;
      for (int i = NODES - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = NODE_W'(i);
         end
      end
      first_set = idx;
   endfunction

endpackage

// ----- rtl/dgr_ctrl.sv -----
// sequencer for edge edits and reachability queries
module dgr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  dgr_pkg::status_type status,
   output dgr_pkg::cmd_type    cmd
);

   dgr_pkg::state_type state_ff;
   dgr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dgr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.rd_sel = dgr_pkg::SEL_A;
      cmd.wr_sel = dgr_pkg::SEL_A;
      case (state_ff)
         dgr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_op)
                  dgr_pkg::OP_QUERY: begin
                     state_in = dgr_pkg::ST_Q_INIT;
                  end
                  dgr_pkg::OP_INSERT, dgr_pkg::OP_DELETE: begin
                     if (status.edit_ok) begin
                        state_in = dgr_pkg::ST_RD_A;
                     end
                  end
                  default: begin
                     state_in = dgr_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         dgr_pkg::ST_RD_A: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = dgr_pkg::SEL_A;
            state_in   = dgr_pkg::ST_WR_A;
         end
         dgr_pkg::ST_WR_A: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = dgr_pkg::SEL_A;
            state_in   = dgr_pkg::ST_RD_B;
         end
         dgr_pkg::ST_RD_B: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = dgr_pkg::SEL_B;
            state_in   = dgr_pkg::ST_WR_B;
         end
         dgr_pkg::ST_WR_B: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = dgr_pkg::SEL_B;
            state_in   = dgr_pkg::ST_IDLE;
         end
         dgr_pkg::ST_Q_INIT: begin
            cmd.q_init = 1'b1;
            state_in   = dgr_pkg::ST_Q_RUN;
         end
         dgr_pkg::ST_Q_RUN: begin
            cmd.expand = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = dgr_pkg::SEL_PICK;
            if (status.q_done) begin
               state_in = dgr_pkg::ST_Q_OUT;
            end
         end
         dgr_pkg::ST_Q_OUT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = dgr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dgr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/dgr_dp.sv -----
// adjacency memory, reached set and result register
module dgr_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_op,
   input  logic [5:0]          req_node_a,
   input  logic [5:0]          req_node_b,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_reachable,
   input  dgr_pkg::cmd_type    cmd,
   output dgr_pkg::status_type status
);

   dgr_pkg::row_type  adj_ff [dgr_pkg::NODES];
   dgr_pkg::row_type  row_valid_ff;
   dgr_pkg::row_type  rd_row_ff;
   logic              rd_valid_ff;
   dgr_pkg::row_type  rd_row;

   logic [1:0]        op_ff;
   dgr_pkg::node_type a_ff;
   dgr_pkg::node_type b_ff;

   dgr_pkg::row_type  reached_ff;
   dgr_pkg::row_type  reached_in;
   dgr_pkg::row_type  expanded_ff;
   dgr_pkg::row_type  expanded_in;
   logic              inflight_ff;
   logic              inflight_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_reachable_ff;
   logic              rsp_reachable_in;

   dgr_pkg::row_type  pending;
   logic              any_pending;
   dgr_pkg::node_type pick;
   dgr_pkg::node_type rd_addr;
   dgr_pkg::node_type wr_addr;
   dgr_pkg::node_type wr_bit;
   dgr_pkg::row_type  wr_row;
   dgr_pkg::row_type  seed;

   // latched request word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         a_ff  <= dgr_pkg::node_type'(req_node_a);
         b_ff  <= dgr_pkg::node_type'(req_node_b);
      end
   end

   assign pending     = reached_ff & ~expanded_ff;
   assign any_pending = |pending;
   assign pick        = dgr_pkg::first_set(pending);

   always_comb begin
      case (cmd.rd_sel)
         dgr_pkg::SEL_A:    rd_addr = a_ff;
         dgr_pkg::SEL_B:    rd_addr = b_ff;
         dgr_pkg::SEL_PICK: rd_addr = pick;
         default:           rd_addr = a_ff;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         dgr_pkg::SEL_B: begin
            wr_addr = b_ff;
            wr_bit  = a_ff;
         end
         default: begin
            wr_addr = a_ff;
            wr_bit  = b_ff;
         end
      endcase
   end

   // rows never written read as empty
   assign rd_row = rd_valid_ff ? rd_row_ff : '0;

   always_comb begin
      wr_row         = rd_row;
      wr_row[wr_bit] = (op_ff == dgr_pkg::OP_INSERT);
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         adj_ff[wr_addr] <= wr_row;
      end
      if (cmd.rd_en) begin
         rd_row_ff   <= adj_ff[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // frontier expansion
   always_comb begin
      seed       = '0;
      seed[a_ff] = dgr_pkg::in_range(a_ff);
      reached_in  = reached_ff;
      expanded_in = expanded_ff;
      inflight_in = 1'b0;
      if (cmd.q_init) begin
         reached_in  = seed;
         expanded_in = '0;
      end else if (cmd.expand) begin
         if (inflight_ff) begin
            reached_in = reached_ff | rd_row;
         end
         if (any_pending) begin
            expanded_in[pick] = 1'b1;
            inflight_in       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reached_ff  <= '0;
         expanded_ff <= '0;
         inflight_ff <= 1'b0;
      end else begin
         reached_ff  <= reached_in;
         expanded_ff <= expanded_in;
         inflight_ff <= inflight_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in     = rsp_valid_ff & ~rsp_ready;
      rsp_reachable_in = rsp_reachable_ff;
      if (cmd.emit) begin
         rsp_valid_in     = 1'b1;
         rsp_reachable_in = (a_ff == b_ff)
                          | (dgr_pkg::in_range(b_ff) & reached_ff[b_ff]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_reachable_ff <= rsp_reachable_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reachable = rsp_reachable_ff;

   assign status.edit_ok  = dgr_pkg::in_range(dgr_pkg::node_type'(req_node_a))
                          & dgr_pkg::in_range(dgr_pkg::node_type'(req_node_b))
                          & (req_node_a != req_node_b);
   assign status.q_done   = ~any_pending & ~inflight_ff;
   assign status.rsp_free = ~rsp_valid_ff | rsp_ready;

endmodule

// ----- rtl/dynamic_graph_reachability_top.sv -----
// top level of the dynamic graph reachability block
// req_ channel: one word per edit or query (op, node_a, node_b), valid/ready.
//   op query asks whether node_b is reachable from node_a, op insert adds the
//   undirected edge, op delete removes it; unused op codes are dropped.
// rsp_ channel: one word (reachable) per query, none for edits, valid/ready.
// req_ready is high only while the sequencer is idle.
// an edit steps through RD_A, WR_A, RD_B, WR_B: each direction of the edge is a
//   read then a write of one adjacency row through the single memory port.
// a query reads one adjacency row per reached vertex in the source's component
//   (at most 64 vertices), and waits out any row still in flight when the
//   frontier runs dry.
// the answer sits in an output register, so the next word is accepted while
//   it waits; a later query holds in its last step until that slot frees.
// reset empties the graph at once through per-row valid flags and clears
//   the result slot; words are accepted once reset is released.
module dynamic_graph_reachability_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [5:0] req_node_a,
   input  logic [5:0] req_node_b,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_reachable
);

   dgr_pkg::cmd_type    cmd;
   dgr_pkg::status_type status;

   dgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   dgr_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_op),
      .req_node_a    (req_node_a),
      .req_node_b    (req_node_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_reachable (rsp_reachable),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

// ----- rtl/dgr_checker.sv -----
// port-level checks of the reachability block and their binding
`include "assert_macros.svh"

module dgr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_op,
   input logic [5:0] req_node_a,
   input logic [5:0] req_node_b,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_reachable
);

   logic edit_acc;
   logic query_acc;

   assign query_acc = req_valid & req_ready & (req_op == dgr_pkg::OP_QUERY);
   assign edit_acc  = req_valid & req_ready & (req_node_a != req_node_b)
                    & ((req_op == dgr_pkg::OP_INSERT) || (req_op == dgr_pkg::OP_DELETE));

   `DGR_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid)
   `DGR_ASSERT(a_rsp_holds, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reachable))
   `DGR_ASSERT(a_edit_busy, edit_acc |=> !req_ready)
   `DGR_ASSERT(a_query_busy, query_acc |=> !req_ready && !$rose(rsp_valid))

endmodule

bind dynamic_graph_reachability_top dgr_checker u_dgr_checker (.*);
